@@ rtl/icfq_pkg.sv @@
// shared types, constants and helpers for the image column fir q16 core
// no dependencies; imported by every module of the block
package icfq_pkg;

    // default sizing, handed to the top level parameters
    localparam int MAX_TAPS_DEF      = 16;
    localparam int MAX_STEP_DEF      = 2048;
    localparam int HISTORY_DEPTH_DEF = 32768;

    // fixed field widths
    localparam int PIX_W        = 8;
    localparam int COEF_W       = 16;
    localparam int ACC_W        = 16;
    localparam int NUM_COEFS    = 16;
    localparam int TAP_COUNT_W  = 5;
    localparam int TAP_STEP_W   = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int COEF_REGS    = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_3    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_REDUCE,
        ST_NORM,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } seq_state_t;

    // sequencer to multiply-accumulate unit
    typedef struct packed {
        logic              clear;
        logic              issue;
        logic [COEF_W-1:0] coef;
    } mac_ctrl_t;

    // signed read of the sum, clamped to pixel range
    function automatic logic [PIX_W-1:0] clamp_pixel(input logic [ACC_W-1:0] acc);
        logic [PIX_W-1:0] res;
        if (acc[ACC_W-1]) begin
            res = '0;
        end else if (acc[ACC_W-2:PIX_W] != '0) begin
            res = '1;
        end else begin
            res = acc[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/image_column_fir_q16_core.sv @@
// Streaming 1-D Q16 FIR over 8-bit pixels with taps tap_step pixels apart.
// Every accepted pixel is written into a single-port history ring, and once
// (tap_count-1)*tap_step+1 pixels have arrived each pixel yields one result
// for the window that ends at that pixel. A pixel that yields no result
// passes through the write and reduce states before the next acceptance;
// one that yields a result also walks the taps in use (1 to 16 after saturation)
// through the ring's single port and the shared multiply-accumulate
// unit, which handle one tap per cycle. The result sits in an output
// register, so the next pixel is accepted while it waits; a following result
// holds the block until the waiting one has been taken. The history ring
// needs no clearing pass after reset.
// depends on icfq_pkg, icfq_hist_ram, icfq_mac, icfq_seq
module image_column_fir_q16_core import icfq_pkg::*; #(
    parameter int MAX_TAPS      = MAX_TAPS_DEF,
    parameter int MAX_STEP      = MAX_STEP_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_filtered,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);

    logic [TAP_COUNT_W-1:0]             tap_count_reg;
    logic [TAP_COUNT_W-1:0]             tap_count_next;
    logic [TAP_STEP_W-1:0]              tap_step_reg;
    logic [TAP_STEP_W-1:0]              tap_step_next;
    logic [COEF_REGS-1:0][CFG_DATA_W-1:0] coef_reg;
    logic [COEF_REGS-1:0][CFG_DATA_W-1:0] coef_next;
    logic [NUM_COEFS-1:0][COEF_W-1:0]   coef_bus;
    logic                               m_valid_reg;
    logic                               m_valid_next;
    logic [PIX_W-1:0]                   m_filtered_reg;
    logic [PIX_W-1:0]                   m_filtered_next;

    mac_ctrl_t          mac_ctrl;
    logic               mac_busy;
    logic [ACC_W-1:0]   mac_acc;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [PIX_W-1:0]   ram_wdata;
    logic [PIX_W-1:0]   ram_rdata;
    logic               out_free;
    logic               res_load;

    // configuration registers, writes past the last index are dropped
    always_comb begin
        tap_count_next = tap_count_reg;
        tap_step_next  = tap_step_reg;
        coef_next      = coef_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_TAP_COUNT: tap_count_next = cfg_data[TAP_COUNT_W-1:0];
                CFG_TAP_STEP:  tap_step_next  = cfg_data[TAP_STEP_W-1:0];
                CFG_COEF_0:    coef_next[0]   = cfg_data;
                CFG_COEF_1:    coef_next[1]   = cfg_data;
                CFG_COEF_2:    coef_next[2]   = cfg_data;
                CFG_COEF_3:    coef_next[3]   = cfg_data;
                default:       tap_count_next = tap_count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= TAP_COUNT_W'(1);
            tap_step_reg  <= TAP_STEP_W'(1);
            coef_reg      <= '0;
        end else begin
            tap_count_reg <= tap_count_next;
            tap_step_reg  <= tap_step_next;
            coef_reg      <= coef_next;
        end
    end

    assign cfg_ready = 1'b1;
    // tap k sits at bits 16*k of the concatenated coefficient registers
    assign coef_bus  = coef_reg;

    // output register
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_filtered_next = m_filtered_reg;
        if (res_load) begin
            m_valid_next    = 1'b1;
            m_filtered_next = clamp_pixel(mac_acc);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_filtered_reg <= m_filtered_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;

    icfq_seq #(
        .MAX_TAPS      (MAX_TAPS),
        .MAX_STEP      (MAX_STEP),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .cfg_tap_count (tap_count_reg),
        .cfg_tap_step  (tap_step_reg),
        .coef_bus      (coef_bus),
        .mac_busy      (mac_busy),
        .mac_ctrl      (mac_ctrl),
        .ram_we        (ram_we),
        .ram_addr      (ram_addr),
        .ram_wdata     (ram_wdata),
        .out_free      (out_free),
        .res_load      (res_load)
    );

    icfq_hist_ram #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    icfq_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .rdata   (ram_rdata),
        .acc     (mac_acc),
        .busy    (mac_busy)
    );

endmodule

@@ rtl/icfq_hist_ram.sv @@
// single-port pixel history ring storage with registered read data
// depends on icfq_pkg for the pixel width
module icfq_hist_ram import icfq_pkg::*; #(
    parameter int  DEPTH  = HISTORY_DEPTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [PIX_W-1:0]  wdata,
    output logic [PIX_W-1:0]  rdata
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/icfq_mac.sv @@
// shared multiply-accumulate unit: one tap per cycle, q16 high half, sum mod 2^16
// depends on icfq_pkg for mac_ctrl_t and widths
module icfq_mac import icfq_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  mac_ctrl_t        ctrl,
    input  logic [PIX_W-1:0] rdata,
    output logic [ACC_W-1:0] acc,
    output logic             busy
);

    localparam int PROD_W = PIX_W + COEF_W;

    logic              v1_reg;
    logic              v1_next;
    logic              v2_reg;
    logic              v2_next;
    logic [COEF_W-1:0] coef1_reg;
    logic [COEF_W-1:0] coef1_next;
    logic [PIX_W-1:0]  prod_hi_reg;
    logic [PIX_W-1:0]  prod_hi_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(rdata) * PROD_W'(coef1_reg);

    always_comb begin
        // coef is registered alongside the ram read so it meets the registered ram data
        v1_next      = ctrl.issue;
        coef1_next   = ctrl.issue ? ctrl.coef : coef1_reg;
        v2_next      = v1_reg;
        prod_hi_next = v1_reg ? prod[PROD_W-1:COEF_W] : prod_hi_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (v2_reg) begin
            acc_next = acc_reg + ACC_W'(prod_hi_reg);
        end else begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        coef1_reg   <= coef1_next;
        prod_hi_reg <= prod_hi_next;
        acc_reg     <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = v1_reg | v2_reg;

endmodule

@@ rtl/icfq_seq.sv @@
// sequencer: ring write, fill tracking, tap address walk and mac issue
// depends on icfq_pkg for the state type, mac_ctrl_t and widths
module icfq_seq import icfq_pkg::*; #(
    parameter int  MAX_TAPS      = MAX_TAPS_DEF,
    parameter int  MAX_STEP      = MAX_STEP_DEF,
    parameter int  HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [PIX_W-1:0]                    s_pixel,
    input  logic [TAP_COUNT_W-1:0]              cfg_tap_count,
    input  logic [TAP_STEP_W-1:0]               cfg_tap_step,
    input  logic [NUM_COEFS-1:0][COEF_W-1:0]    coef_bus,
    input  logic                                mac_busy,
    output mac_ctrl_t                           mac_ctrl,
    output logic                                ram_we,
    output logic [ADDR_W-1:0]                   ram_addr,
    output logic [PIX_W-1:0]                    ram_wdata,
    input  logic                                out_free,
    output logic                                res_load
);

    localparam int TAP_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int STEP_W = $clog2(MAX_STEP + 1);
    localparam int SPAN_W = $clog2((MAX_TAPS - 1) * MAX_STEP + 2);
    localparam int SP_W   = TAP_W + STEP_W;
    // step mod depth via reciprocal multiply, at most one correction
    localparam int SH     = STEP_W + ADDR_W;
    localparam int RCP_W  = STEP_W + 1;
    localparam int PQ_W   = STEP_W + RCP_W;
    localparam int R_W    = STEP_W + ADDR_W + 1;
    localparam logic [63:0]      RECIP_FULL = (64'd1 << SH) / 64'(HISTORY_DEPTH);
    localparam logic [RCP_W-1:0] RECIP      = RCP_W'(RECIP_FULL);
    localparam logic [ADDR_W:0]  DEPTH_X    = (ADDR_W + 1)'(HISTORY_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(HISTORY_DEPTH - 1);

    seq_state_t         state_reg;
    seq_state_t         state_next;
    logic [PIX_W-1:0]   pix_reg;
    logic [PIX_W-1:0]   pix_next;
    logic [ADDR_W-1:0]  wp_reg;
    logic [ADDR_W-1:0]  wp_next;
    logic [SPAN_W-1:0]  fill_reg;
    logic [SPAN_W-1:0]  fill_next;
    logic [SPAN_W-1:0]  span_m1_reg;
    logic [SPAN_W-1:0]  span_m1_next;
    logic [STEP_W-1:0]  q_reg;
    logic [STEP_W-1:0]  q_next;
    logic [ADDR_W:0]    r_reg;
    logic [ADDR_W:0]    r_next;
    logic [ADDR_W-1:0]  step_mod_reg;
    logic [ADDR_W-1:0]  step_mod_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    logic [TAP_W-1:0]   k_reg;
    logic [TAP_W-1:0]   k_next;

    logic [TAP_W-1:0]   taps_m1;
    logic [STEP_W-1:0]  step_eff;
    logic [SP_W-1:0]    span_prod;
    logic [PQ_W-1:0]    q_prod;
    logic [R_W-1:0]     qd;
    logic [R_W-1:0]     r_full;
    logic [ADDR_W:0]    addr_wrap;
    logic [ADDR_W-1:0]  addr_dec;
    logic [ADDR_W-1:0]  wp_inc;
    logic [SPAN_W-1:0]  fill_new;
    logic               emit;

    // effective tap count and step
    always_comb begin
        if (cfg_tap_count == '0) begin
            taps_m1 = '0;
        end else if (32'(cfg_tap_count) > MAX_TAPS) begin
            taps_m1 = TAP_W'(MAX_TAPS - 1);
        end else begin
            taps_m1 = TAP_W'(cfg_tap_count - 1'b1);
        end
        if (cfg_tap_step == '0) begin
            step_eff = STEP_W'(1);
        end else if (32'(cfg_tap_step) > MAX_STEP) begin
            step_eff = STEP_W'(MAX_STEP);
        end else begin
            step_eff = STEP_W'(cfg_tap_step);
        end
    end

    assign span_prod = SP_W'(taps_m1) * SP_W'(step_eff);
    assign q_prod    = PQ_W'(step_eff) * PQ_W'(RECIP);
    assign qd        = R_W'(q_reg) * R_W'(HISTORY_DEPTH);
    assign r_full    = R_W'(step_eff) - qd;

    assign wp_inc    = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
    assign addr_wrap = {1'b0, addr_reg} + DEPTH_X - {1'b0, step_mod_reg};
    assign addr_dec  = (addr_reg >= step_mod_reg) ? addr_reg - step_mod_reg
                                                  : ADDR_W'(addr_wrap);

    // fill saturates at the window span, emit once a full window is held
    assign fill_new = (fill_reg <= span_m1_reg) ? fill_reg + 1'b1 : fill_reg;
    assign emit     = fill_new > span_m1_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = ST_REDUCE;
            end
            ST_REDUCE: begin
                state_next = emit ? ST_NORM : ST_IDLE;
            end
            ST_NORM: begin
                state_next = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (k_reg == '0) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!mac_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready        = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = addr_reg;
        ram_wdata      = pix_reg;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.issue = 1'b0;
        mac_ctrl.coef  = '0;
        res_load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_WRITE: begin
                ram_we   = 1'b1;
                ram_addr = wp_reg;
            end
            ST_NORM: begin
                mac_ctrl.clear = 1'b1;
            end
            ST_ISSUE: begin
                mac_ctrl.issue = 1'b1;
                // taps past the coefficient registers weigh zero
                if (32'(k_reg) < NUM_COEFS) begin
                    mac_ctrl.coef = coef_bus[4'(k_reg)];
                end
            end
            ST_FINISH: begin
                res_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb begin
        pix_next      = pix_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        span_m1_next  = span_m1_reg;
        q_next        = q_reg;
        r_next        = r_reg;
        step_mod_next = step_mod_reg;
        addr_next     = addr_reg;
        k_next        = k_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pix_next = s_pixel;
                end
            end
            ST_WRITE: begin
                wp_next      = wp_inc;
                span_m1_next = SPAN_W'(span_prod);
                q_next       = STEP_W'(q_prod >> SH);
                addr_next    = wp_reg;
            end
            ST_REDUCE: begin
                fill_next = fill_new;
                r_next    = (ADDR_W + 1)'(r_full);
            end
            ST_NORM: begin
                step_mod_next = (r_reg >= DEPTH_X) ? ADDR_W'(r_reg - DEPTH_X)
                                                   : ADDR_W'(r_reg);
                k_next        = taps_m1;
            end
            ST_ISSUE: begin
                // newest tap first, walking back one step per cycle
                addr_next = addr_dec;
                k_next    = k_reg - 1'b1;
            end
            default: begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg      <= pix_next;
        span_m1_reg  <= span_m1_next;
        q_reg        <= q_next;
        r_reg        <= r_next;
        step_mod_reg <= step_mod_next;
        addr_reg     <= addr_next;
        k_reg        <= k_next;
    end

endmodule

@@ test/image_column_fir_q16_core_test.sv @@
// self-checking testbench for image_column_fir_q16_core: a tracker class predicts
// each filtered pixel from its own history ring, and plain tasks drive the requests
// depends on icfq_pkg and the rtl of image_column_fir_q16_core
module image_column_fir_q16_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import icfq_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam int    RANDOM_ITEMS = 1900;
    localparam int    SETTLE_CYCLES = 40;
    localparam int    MAX_SHOWN = 40;
    localparam longint TIMEOUT_NS = 400_000_000;

    class column_fir_tracker;
        bit [PIX_W-1:0]       ring [HISTORY_DEPTH_DEF];
        int unsigned          wr_ptr;
        int unsigned          fill;
        int unsigned          pixels_seen;
        bit [TAP_COUNT_W-1:0] taps_reg;
        bit [TAP_STEP_W-1:0]  step_reg;
        bit [CFG_DATA_W-1:0]  coef_reg [COEF_REGS];
        bit [PIX_W-1:0]       filtered_due [$];
        int unsigned          mismatches;
        int unsigned          results_seen;
        int unsigned          cfg_writes;

        function new();
            taps_reg = 1;
            step_reg = 1;
            foreach (coef_reg[i]) coef_reg[i] = '0;
            wr_ptr = 0;
            fill = 0;
            pixels_seen = 0;
            mismatches = 0;
            results_seen = 0;
            cfg_writes = 0;
        endfunction

        function int unsigned taps_used();
            if (taps_reg == 0) return 1;
            if (taps_reg > MAX_TAPS_DEF) return MAX_TAPS_DEF;
            return taps_reg;
        endfunction

        function int unsigned step_used();
            if (step_reg == 0) return 1;
            if (step_reg > MAX_STEP_DEF) return MAX_STEP_DEF;
            return step_reg;
        endfunction

        function int unsigned window_span();
            return (taps_used() - 1) * step_used() + 1;
        endfunction

        function int unsigned pixels_to_prime();
            if (fill >= window_span()) return 0;
            return window_span() - fill;
        endfunction

        function int pending();
            return filtered_due.size();
        endfunction

        function bit [COEF_W-1:0] coef_of_tap(int unsigned k);
            bit [CFG_DATA_W-1:0] w;
            w = coef_reg[k / 4];
            return w[16 * (k % 4) +: 16];
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            cfg_writes++;
            case (idx)
                CFG_TAP_COUNT: taps_reg = data[TAP_COUNT_W-1:0];
                CFG_TAP_STEP:  step_reg = data[TAP_STEP_W-1:0];
                CFG_COEF_0:    coef_reg[0] = data;
                CFG_COEF_1:    coef_reg[1] = data;
                CFG_COEF_2:    coef_reg[2] = data;
                CFG_COEF_3:    coef_reg[3] = data;
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px);
            int unsigned t, s, here, back, idx, k;
            bit [ACC_W-1:0] sum;
            bit [31:0] prod;
            bit [PIX_W-1:0] res;
            t = taps_used();
            s = step_used();
            here = wr_ptr;
            ring[here] = px;
            wr_ptr = (here + 1) % HISTORY_DEPTH_DEF;
            pixels_seen++;
            if (fill < window_span()) fill++;
            if (fill < window_span()) return;
            sum = '0;
            for (k = 0; k < t; k++) begin
                back = ((t - 1 - k) * s) % HISTORY_DEPTH_DEF;
                idx = (here + HISTORY_DEPTH_DEF - back) % HISTORY_DEPTH_DEF;
                prod = ring[idx] * coef_of_tap(k);
                sum = sum + prod[31:16];
            end
            // signed read of the sum, then clamp to the pixel range
            if (sum[ACC_W-1]) begin
                res = '0;
            end else if (sum > 255) begin
                res = '1;
            end else begin
                res = sum[PIX_W-1:0];
            end
            filtered_due.push_back(res);
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_filtered(logic [PIX_W-1:0] got);
            bit [PIX_W-1:0] want;
            results_seen++;
            if (filtered_due.size() == 0) begin
                flag_mismatch($sformatf("result %0d with none outstanding", got));
                return;
            end
            want = filtered_due.pop_front();
            if (got !== want) begin
                flag_mismatch($sformatf("filtered %0d, predicted %0d (result %0d)",
                                        got, want, results_seen));
            end
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic [PIX_W-1:0]      s_pixel = '0;
    logic                  m_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    wire                   s_ready;
    wire                   m_valid;
    wire  [PIX_W-1:0]      m_filtered;
    wire                   cfg_ready;

    column_fir_tracker fir = new();
    bit          calm = 1'b0;
    int          ready_left = 0;
    bit          ready_now = 1'b0;
    int unsigned drain_pauses = 0;
    int unsigned settings = 0;

    image_column_fir_q16_core uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel    (s_pixel),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #6 aclk = ~aclk;

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coefs();
        logic [CFG_DATA_W-1:0] w;
        int r, i;
        r = $urandom_range(0, 4);
        case (r)
            0: w = {$urandom, $urandom};
            1: w = '1;
            2: w = '0;
            default: begin
                for (i = 0; i < 4; i++) w[16 * i +: 16] = COEF_W'($urandom_range(0, 16'h3000));
            end
        endcase
        return w;
    endfunction

    // result side stalls
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            if (calm || $urandom_range(0, 2) != 0) begin
                ready_now = 1'b1;
                ready_left = $urandom_range(1, 40);
            end else begin
                ready_now = 1'b0;
                ready_left = idle_len();
                if (ready_left == 0) ready_left = 1;
            end
        end
        ready_left = ready_left - 1;
        m_ready <= ready_now;
    end

    // results are checked before the same edge's request is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) fir.check_filtered(m_filtered);
            if (s_valid && s_ready) fir.note_pixel(s_pixel);
            if (cfg_valid && cfg_ready) fir.note_config(cfg_index, cfg_data);
        end
    end

    task automatic send_pixel(logic [PIX_W-1:0] px);
        int gap;
        gap = idle_len();
        if (!calm && $urandom_range(0, 249) == 0) begin
            // hold the next request until every result is out
            drain_pauses++;
            s_valid <= 1'b0;
            @(posedge aclk);
            while (fir.pending() != 0) @(posedge aclk);
        end else if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic stream(int unsigned n);
        repeat (n) send_pixel(pick_pixel());
    endtask

    // pixels that give no result may still be in flight, hence the extra cycles
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (fir.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic close_config();
        cfg_valid <= 1'b0;
        settings++;
        @(posedge aclk);
    endtask

    task automatic random_setting();
        logic [CFG_DATA_W-1:0] d;
        int r, i;
        if ($urandom_range(0, 4) != 0) begin
            d = {$urandom, $urandom};
            r = $urandom_range(0, 9);
            if (r == 0) d[TAP_COUNT_W-1:0] = '0;
            else if (r == 1) d[TAP_COUNT_W-1:0] = TAP_COUNT_W'($urandom_range(17, 31));
            else if (r == 2) d[TAP_COUNT_W-1:0] = TAP_COUNT_W'(MAX_TAPS_DEF);
            else d[TAP_COUNT_W-1:0] = TAP_COUNT_W'($urandom_range(1, 8));
            write_reg(CFG_TAP_COUNT, d);
        end
        if ($urandom_range(0, 4) != 0) begin
            d = {$urandom, $urandom};
            r = $urandom_range(0, 9);
            if (r == 0) d[TAP_STEP_W-1:0] = '0;
            else if (r == 1) d[TAP_STEP_W-1:0] = TAP_STEP_W'($urandom_range(9, 64));
            else d[TAP_STEP_W-1:0] = TAP_STEP_W'($urandom_range(1, 8));
            write_reg(CFG_TAP_STEP, d);
        end
        for (i = 0; i < COEF_REGS; i++) begin
            if ($urandom_range(0, 9) < 7) write_reg(CFG_IDX_W'(CFG_COEF_0 + i), pick_coefs());
        end
        if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
        end
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int unsigned n, prime;
        bit calm_phase;
        int i;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setting: one tap, zero coefficient
        send_pixel(8'h00);
        send_pixel(8'hFF);
        settle();

        // single full-scale tap, spare indexes must be ignored
        write_reg(CFG_COEF_0, 64'h0000_0000_0000_FFFF);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);
        close_config();
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h01);
        send_pixel(8'hAA);
        settle();

        // zero taps behaves as one
        write_reg(CFG_TAP_COUNT, 64'd0);
        close_config();
        send_pixel(8'h55);
        settle();

        // tap count and step out of range, all coefficients at full scale;
        // the wider window has to prime again before results flow
        write_reg(CFG_TAP_COUNT, 64'd31);
        write_reg(CFG_TAP_STEP, 64'd0);
        for (i = 0; i < COEF_REGS; i++) write_reg(CFG_IDX_W'(CFG_COEF_0 + i), '1);
        close_config();
        repeat (15) send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h80);
        send_pixel(8'h7F);

        while (fir.pixels_seen < RANDOM_ITEMS) begin
            settle();
            calm = 1'b0;
            random_setting();
            calm_phase = ($urandom_range(0, 5) == 0);
            close_config();
            prime = fir.pixels_to_prime();
            n = $urandom_range(30, 110);
            // long priming runs without gaps
            calm = (prime > 400) ? 1'b1 : calm_phase;
            stream(prime);
            calm = calm_phase;
            stream(n);
        end

        settle();
        $display("run covered %0d pixels and %0d results over %0d settings, %0d register writes",
                 fir.pixels_seen, fir.results_seen, settings, fir.cfg_writes);
        $display("windows up to %0d taps, out-of-range tap counts and steps, %0d drain pauses",
                 MAX_TAPS_DEF, drain_pauses);
        if (fir.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
